FILE: src/quaternion_to_euler_macros.svh
// Assertion macros shared by the quaternion to Euler checker.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QTE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("quaternion_to_euler assertion failed");

// Next-cycle implication, disabled while reset is held.
`define QTE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("quaternion_to_euler assertion failed");

`endif

FILE: src/qte_pkg.sv
// Shared types, constants and helpers of the quaternion to Euler converter.
package qte_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_USER_W  = 2;
    localparam int TERM_W      = 34;
    localparam int SQRT_BITS   = 32;
    localparam int ATAN_LEN    = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    localparam logic signed [TERM_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [15:0]       PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]       HALF_PI_Q13 = 16'sd12868;

    localparam logic signed [TERM_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // One classified item on its way from the front part to the back part.
    typedef struct packed {
        logic [31:0]              nn;
        logic [31:0]              pp;
        logic signed [TERM_W-1:0] roll_y;
        logic signed [TERM_W-1:0] roll_x;
        logic signed [TERM_W-1:0] yaw_y;
        logic signed [TERM_W-1:0] yaw_x;
        logic                     degen;
        logic                     gimbal;
        logic                     neg;
    } t_job;

    // Control that rides alongside the angle pipelines.
    typedef struct packed {
        logic valid;
        logic degen;
        logic gimbal;
        logic neg;
    } t_tag;

    // Q30 radians to Q13, rounded half up, saturated to +-lim.
    function automatic logic signed [15:0] to_q13(input logic signed [TERM_W-1:0] z,
                                                  input logic signed [15:0] lim);
        logic signed [TERM_W:0] s;
        logic signed [17:0]     r;
        s = (TERM_W+1)'(z) + 35'sd65536;
        r = 18'(s >>> 17);
        if (r > 18'(lim)) begin
            r = 18'(lim);
        end else if (r < -18'(lim)) begin
            r = -18'(lim);
        end
        return 16'(r);
    endfunction

endpackage

FILE: src/qte_front.sv
// Front part: products, sums and classification of each quaternion.
module qte_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    output qte_pkg::t_job      o_job
);
    import qte_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wz, r_xy, r_wy, r_zx;
    logic [32:0]        r_n2;
    logic signed [TERM_W-1:0] r_ry, r_rx, r_yw_y, r_yw_x, r_a;
    t_job               r_job;

    logic signed [TERM_W:0]   n_rx, n_yx;
    logic [TERM_W-1:0]        a_abs;
    logic [32:0]              aa;
    logic                     degen, gimbal, big;
    t_job                     n_job;

    // The x terms are n2 - 2(x*x + y*y) and n2 - 2(y*y + z*z), taken straight from the
    // squares of the same item.
    always_comb begin
        n_rx = (35'(r_ww) + 35'(r_zz)) - (35'(r_xx) + 35'(r_yy));
        n_yx = (35'(r_ww) + 35'(r_xx)) - (35'(r_yy) + 35'(r_zz));
    end

    always_comb begin
        a_abs  = r_a[TERM_W-1] ? $unsigned(-r_a) : $unsigned(r_a);
        aa     = a_abs[32:0];
        degen  = (r_n2 == '0);
        gimbal = !degen && (aa >= r_n2);
        big    = (r_n2[32:31] != 2'b00);
        n_job        = '0;
        n_job.roll_y = r_ry;
        n_job.roll_x = r_rx;
        n_job.yaw_y  = r_yw_y;
        n_job.yaw_x  = r_yw_x;
        n_job.degen  = degen;
        n_job.gimbal = gimbal;
        n_job.neg    = r_a[TERM_W-1];
        // The pitch square root is only meaningful inside the unit range.
        if (!degen && !gimbal) begin
            n_job.nn = big ? r_n2[32:1] : r_n2[31:0];
            n_job.pp = big ? aa[32:1] : aa[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww   <= i_quat_w * i_quat_w;
            r_xx   <= i_quat_x * i_quat_x;
            r_yy   <= i_quat_y * i_quat_y;
            r_zz   <= i_quat_z * i_quat_z;
            r_wx   <= i_quat_w * i_quat_x;
            r_yz   <= i_quat_y * i_quat_z;
            r_wz   <= i_quat_w * i_quat_z;
            r_xy   <= i_quat_x * i_quat_y;
            r_wy   <= i_quat_w * i_quat_y;
            r_zx   <= i_quat_z * i_quat_x;
            r_n2   <= 33'(r_ww) + 33'(r_xx) + 33'(r_yy) + 33'(r_zz);
            r_ry   <= (34'(r_wx) + 34'(r_yz)) <<< 1;
            r_rx   <= TERM_W'(n_rx);
            r_yw_y <= (34'(r_wz) + 34'(r_xy)) <<< 1;
            r_yw_x <= TERM_W'(n_yx);
            r_a    <= (34'(r_wy) - 34'(r_zx)) <<< 1;
            r_job  <= n_job;
        end
    end

    assign o_valid = r_v3;
    assign o_job   = r_job;

endmodule

FILE: src/qte_fifo.sv
// Short queue that decouples the front part from the back part.
module qte_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qte_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output qte_pkg::t_job o_data
);
    import qte_pkg::*;

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, r_rp;
    logic [FIFO_CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/qte_sqrt.sv
// Pitch leg: nn*nn - pp*pp and a pipelined integer square root, one bit per stage.
module qte_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  qte_pkg::t_job                 i_job,
    output logic                          o_valid,
    output logic [qte_pkg::SQRT_BITS-1:0] o_root,
    output qte_pkg::t_job                 o_job
);
    import qte_pkg::*;

    logic [63:0]            r_nn2, r_pp2;
    logic [63:0]            r_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0]   r_res  [SQRT_BITS+1];
    t_job                   r_side [SQRT_BITS+2];
    logic [SQRT_BITS+1:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_BITS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn2     <= 64'(i_job.nn) * 64'(i_job.nn);
            r_pp2     <= 64'(i_job.pp) * 64'(i_job.pp);
            r_side[0] <= i_job;
            r_rem[0]  <= r_nn2 - r_pp2;
            r_res[0]  <= '0;
            r_side[1] <= r_side[0];
        end
    end

    // The remainder stays equal to the radicand minus the square of the partial root.
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
        localparam int K = SQRT_BITS - 1 - j;
        logic [63:0] trial;
        logic        fit;
        assign trial = (64'(r_res[j]) << (K + 1)) | (64'd1 << (2 * K));
        assign fit   = (r_rem[j] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= fit ? (r_rem[j] - trial) : r_rem[j];
                r_res[j+1]  <= fit ? (r_res[j] | (SQRT_BITS'(1) << K)) : r_res[j];
                r_side[j+2] <= r_side[j+1];
            end
        end
    end

    assign o_valid = r_vld[SQRT_BITS+1];
    assign o_root  = r_res[SQRT_BITS];
    assign o_job   = r_side[SQRT_BITS+1];

endmodule

FILE: src/qte_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians.
module qte_cordic #(
    parameter int ITER = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qte_pkg::TERM_W-1:0]  i_y,
    input  logic signed [qte_pkg::TERM_W-1:0]  i_x,
    output logic signed [qte_pkg::TERM_W-1:0]  o_z
);
    import qte_pkg::*;

    localparam int CW   = 46;
    localparam int MW   = 41;
    localparam int NORM = 6;

    logic signed [CW-1:0]     r_nx [NORM+1];
    logic signed [CW-1:0]     r_ny [NORM+1];
    logic [MW-1:0]            r_nm [NORM+1];
    logic                     r_nz [NORM+1];
    logic signed [CW-1:0]     r_ix [ITER+1];
    logic signed [CW-1:0]     r_iy [ITER+1];
    logic signed [TERM_W-1:0] r_iz [ITER+1];
    logic                     r_iq [ITER+1];

    logic [TERM_W-1:0] ax, ay;

    assign ax = i_x[TERM_W-1] ? $unsigned(-i_x) : $unsigned(i_x);
    assign ay = i_y[TERM_W-1] ? $unsigned(-i_y) : $unsigned(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= CW'(i_x);
            r_ny[0] <= CW'(i_y);
            r_nm[0] <= MW'((ax > ay) ? ax : ay);
            r_nz[0] <= (ax == '0) && (ay == '0);
        end
    end

    // Binary search for the left shift that sets the top bit of the larger magnitude.
    for (genvar j = 0; j < NORM; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic hit;
        assign hit = (r_nm[j][MW-1 -: SH] == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j+1] <= hit ? (r_nx[j] <<< SH) : r_nx[j];
                r_ny[j+1] <= hit ? (r_ny[j] <<< SH) : r_ny[j];
                r_nm[j+1] <= hit ? (r_nm[j] << SH) : r_nm[j];
                r_nz[j+1] <= r_nz[j];
            end
        end
    end

    // Fold the left half plane into the right one.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_iq[0] <= r_nz[NORM];
            if (r_nx[NORM][CW-1]) begin
                r_ix[0] <= -r_nx[NORM];
                r_iy[0] <= -r_ny[NORM];
                r_iz[0] <= r_ny[NORM][CW-1] ? -PI_Q30 : PI_Q30;
            end else begin
                r_ix[0] <= r_nx[NORM];
                r_iy[0] <= r_ny[NORM];
                r_iz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        logic                 dn;
        logic signed [CW-1:0] sx, sy;
        assign dn = r_iy[i][CW-1];
        assign sx = r_iy[i] >>> i;
        assign sy = r_ix[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ix[i+1] <= dn ? (r_ix[i] - sx) : (r_ix[i] + sx);
                r_iy[i+1] <= dn ? (r_iy[i] + sy) : (r_iy[i] - sy);
                r_iz[i+1] <= dn ? (r_iz[i] - ATAN_Q30[i]) : (r_iz[i] + ATAN_Q30[i]);
                r_iq[i+1] <= r_iq[i];
            end
        end
    end

    assign o_z = r_iq[ITER] ? '0 : r_iz[ITER];

endmodule

FILE: src/quaternion_to_euler.sv
// Quaternion to roll, pitch and yaw converter, top level.
// Throughput: one item per cycle while the receiver keeps up; items pass through the front
// stages, the four-entry queue, the square root and the CORDIC chain to the output register.
// Reset (synchronous, active low) clears all valid bits and the queue pointers;
// the datapath registers are not reset and carry no meaning until an item passes.
module quaternion_to_euler #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  logic [qte_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero [47]
    output logic [qte_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // gimbal_flag [0], degenerate_flag [1]
    output logic [qte_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);
    import qte_pkg::*;

    // Iteration counts past the table length behave as the table length.
    localparam int CORDIC_N = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam int CLAT     = CORDIC_N + 8;

    // Front side: the three front stages move whenever their last stage can drain.
    logic  front_en, front_valid, fifo_full, fifo_empty, fifo_push, fifo_pop;
    t_job  front_job, fifo_job;

    // Back side: the whole back pipeline moves whenever the output register is free.
    logic  back_en;
    logic  sq_valid;
    logic [SQRT_BITS-1:0] sq_root;
    t_job  sq_job;

    logic signed [TERM_W-1:0] pitch_y, pitch_x, z_roll, z_pitch, z_yaw;
    t_tag  r_tag [CLAT];
    t_tag  tag_last;

    logic               r_out_valid;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;
    logic               r_gimbal, r_degen;

    assign fifo_push       = front_valid && !fifo_full;
    assign front_en        = !front_valid || !fifo_full;
    assign o_s_axis_tready = front_en;

    assign back_en  = !r_out_valid || i_m_axis_tready;
    assign fifo_pop = back_en && !fifo_empty;

    qte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (front_en),
        .i_valid  (i_s_axis_tvalid),
        .i_quat_w (i_s_axis_tdata[15:0]),
        .i_quat_x (i_s_axis_tdata[31:16]),
        .i_quat_y (i_s_axis_tdata[47:32]),
        .i_quat_z (i_s_axis_tdata[63:48]),
        .o_valid  (front_valid),
        .o_job    (front_job)
    );

    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (front_job),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_empty (fifo_empty),
        .o_data  (fifo_job)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (fifo_pop),
        .i_job   (fifo_job),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_job   (sq_job)
    );

    // Pitch is atan2 of the signed pitch term against the cosine leg from the root.
    assign pitch_y = sq_job.neg ? -TERM_W'(sq_job.pp) : TERM_W'(sq_job.pp);
    assign pitch_x = TERM_W'(sq_root);

    qte_cordic #(.ITER(CORDIC_N)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (back_en),
        .i_y   (sq_job.roll_y),
        .i_x   (sq_job.roll_x),
        .o_z   (z_roll)
    );

    qte_cordic #(.ITER(CORDIC_N)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (back_en),
        .i_y   (pitch_y),
        .i_x   (pitch_x),
        .o_z   (z_pitch)
    );

    qte_cordic #(.ITER(CORDIC_N)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (back_en),
        .i_y   (sq_job.yaw_y),
        .i_x   (sq_job.yaw_x),
        .o_z   (z_yaw)
    );

    // Valid and flags travel beside the CORDIC chain with the same number of stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLAT; k++) begin
                r_tag[k] <= '0;
            end
        end else if (back_en) begin
            r_tag[0] <= '{valid: sq_valid, degen: sq_job.degen,
                          gimbal: sq_job.gimbal, neg: sq_job.neg};
            for (int k = 1; k < CLAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign tag_last = r_tag[CLAT-1];

    // Output register: scaling to Q13, clamping and the special cases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (back_en) begin
            r_out_valid <= tag_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_degen  <= tag_last.degen;
            r_gimbal <= tag_last.gimbal;
            if (tag_last.degen) begin
                r_roll  <= '0;
                r_yaw   <= '0;
                r_pitch <= '0;
            end else begin
                r_roll <= to_q13(z_roll, PI_Q13);
                r_yaw  <= to_q13(z_yaw, PI_Q13);
                if (tag_last.gimbal) begin
                    r_pitch <= tag_last.neg ? -15'(HALF_PI_Q13) : 15'(HALF_PI_Q13);
                end else begin
                    r_pitch <= 15'(to_q13(z_pitch, HALF_PI_Q13));
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_yaw, r_pitch, r_roll};
    assign o_m_axis_tuser  = {r_degen, r_gimbal};

endmodule

FILE: src/qte_checker.sv
// Port-level checks for the quaternion to Euler converter, bound to the top level.
`include "quaternion_to_euler_macros.svh"

module qte_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [qte_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input logic [qte_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);
    import qte_pkg::*;

    logic signed [14:0] pitch;
    assign pitch = $signed(o_m_axis_tdata[30:16]);

    `QTE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `QTE_ASSERT_IMP(a_pitch_range, i_clk, i_rst_n, o_m_axis_tvalid, (pitch <= 15'(HALF_PI_Q13)) && (pitch >= -15'(HALF_PI_Q13)))
    `QTE_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1], (o_m_axis_tdata == '0) && !o_m_axis_tuser[0])
    `QTE_ASSERT_IMP(a_gimbal_clamp, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], (pitch == 15'(HALF_PI_Q13)) || (pitch == -15'(HALF_PI_Q13)))

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (.*);

FILE: dv/quaternion_to_euler_checker.sv
// Checker for the quaternion to Euler converter: it predicts each result and compares it.
module quaternion_to_euler_checker #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [qte_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [qte_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic [qte_pkg::OUT_USER_W-1:0] i_m_axis_tuser,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_gimbal_seen,
    output int                             o_degen_seen
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               gimbal;
        logic               degen;
    } t_euler;

    localparam int STEPS = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam longint PI_Q30_L = 64'sd3373259426;

    t_euler angles_due[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC atan2 in Q30 radians.
    function automatic longint atan2_q30(input longint y, input longint x);
        longint z;
        longint m;
        longint nx;
        longint ny;
        z = 0;
        m = ((x < 0) ? -x : x) > ((y < 0) ? -y : y) ? ((x < 0) ? -x : x)
                                                     : ((y < 0) ? -y : y);
        if (m == 0) return 0;
        while (m < (64'sd1 <<< 40)) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(qte_pkg::ATAN_Q30[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(qte_pkg::ATAN_Q30[i]);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Q30 to Q13 rounded half up, then saturated.
    function automatic longint q30_to_q13(input longint z, input longint lim);
        longint r;
        r = (z + 65536) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler euler_angles_of(input logic [63:0] q);
        longint w, x, y, z, n2, a;
        longint unsigned aa, nn, pp, c;
        t_euler e;
        w  = longint'($signed(q[15:0]));
        x  = longint'($signed(q[31:16]));
        y  = longint'($signed(q[47:32]));
        z  = longint'($signed(q[63:48]));
        n2 = w*w + x*x + y*y + z*z;
        e  = '0;
        if (n2 == 0) begin
            e.degen = 1'b1;
        end else begin
            a  = 2 * (w*y - z*x);
            aa = (a < 0) ? -a : a;
            e.roll = 16'(q30_to_q13(atan2_q30(2*(w*x + y*z), n2 - 2*(x*x + y*y)), 25736));
            e.yaw  = 16'(q30_to_q13(atan2_q30(2*(w*z + x*y), n2 - 2*(y*y + z*z)), 25736));
            if (aa >= longint'(n2)) begin
                e.gimbal = 1'b1;
                e.pitch  = (a > 0) ? 15'sd12868 : -15'sd12868;
            end else begin
                nn = n2;
                pp = aa;
                // Large norms are halved so the squares stay in range.
                if (nn >= (64'd1 << 31)) begin
                    nn = nn >> 1;
                    pp = pp >> 1;
                end
                c = int_sqrt(nn*nn - pp*pp);
                e.pitch = 15'(q30_to_q13(atan2_q30((a < 0) ? -longint'(pp) : longint'(pp),
                                                   longint'(c)), 12868));
            end
        end
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_euler exp_e;
        t_euler got;
        if (i_rst_n && i_s_axis_tvalid && i_s_axis_tready)
            angles_due.push_back(euler_angles_of(i_s_axis_tdata));
        if (i_rst_n && i_m_axis_tvalid && i_m_axis_tready) begin
            got.roll   = i_m_axis_tdata[15:0];
            got.pitch  = i_m_axis_tdata[30:16];
            got.yaw    = i_m_axis_tdata[46:31];
            got.gimbal = i_m_axis_tuser[0];
            got.degen  = i_m_axis_tuser[1];
            o_results <= o_results + 1;
            if (got.gimbal) o_gimbal_seen <= o_gimbal_seen + 1;
            if (got.degen) o_degen_seen <= o_degen_seen + 1;
            if (angles_due.size() == 0) begin
                if (o_errors < 10) $display("unexpected result roll=%0d pitch=%0d yaw=%0d",
                                            got.roll, got.pitch, got.yaw);
                o_errors <= o_errors + 1;
            end else begin
                exp_e = angles_due.pop_front();
                if (got !== exp_e || i_m_axis_tdata[47] !== 1'b0) begin
                    if (o_errors < 10)
                        $display("mismatch: expected r=%0d p=%0d y=%0d g=%b d=%b, got r=%0d p=%0d y=%0d g=%b d=%b pad=%b",
                                 exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.gimbal, exp_e.degen,
                                 got.roll, got.pitch, got.yaw, got.gimbal, got.degen,
                                 i_m_axis_tdata[47]);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= angles_due.size();
    end

    initial begin
        o_errors      = 0;
        o_pending     = 0;
        o_results     = 0;
        o_gimbal_seen = 0;
        o_degen_seen  = 0;
    end

endmodule

FILE: dv/tb_quaternion_to_euler.sv
// Testbench top for the quaternion to Euler converter: stimulus, handshake pressure, verdict.
module tb_quaternion_to_euler;

    localparam int RANDOM_ITEMS = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        no_idle = 1'b0;   // When set, neither side idles.
    int          errors, pending, results, gimbal_seen, degen_seen;
    int          sent = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_euler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    quaternion_to_euler_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results),
        .o_gimbal_seen   (gimbal_seen),
        .o_degen_seen    (degen_seen)
    );

    // The receiver stalls about 35 percent of the time unless idling is switched off.
    always @(posedge i_clk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 35);
    end

    // Offers one quaternion, possibly after some idle cycles, and waits until it is taken.
    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
        while (!no_idle && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    // A component with a random magnitude scale, so small and mid-size norms show up too.
    function automatic logic signed [15:0] rand_part();
        logic signed [15:0] v;
        v = 16'($urandom);
        return v >>> $urandom_range(15);
    endfunction

    initial begin
        logic signed [15:0] r;
        logic signed [15:0] d;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, the zero quaternion, gimbal lock both ways, large norms.
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, -16384, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(0, 11585, 0, -11585);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-32768, 0, 0, 0);
        send_quat(0, 0, -32768, 0);
        send_quat(1, 0, 0, 0);
        send_quat(0, 0, 0, -1);
        send_quat(0, 1, 0, 0);
        send_quat(1, 1, 1, 1);
        send_quat(-1, 0, 1, 0);
        send_quat(11585, 11585, 0, 0);
        send_quat(0, 0, 11585, 11585);
        send_quat(32767, 0, 32766, 0);

        // Random part: full-range, scaled and near-gimbal quaternions, and ones with x = +-w and z = 0.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle <= (i >= 200 && i < 320);
            if (i == 400) begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(posedge i_clk);
            end
            case ($urandom_range(3))
                0: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: send_quat(rand_part(), rand_part(), rand_part(), rand_part());
                2: begin
                    r = rand_part();
                    d = 16'($signed(4'($urandom)) >>> 1);
                    send_quat(r, d, ($urandom_range(1) ? r : -r) + d, -d);
                end
                default: begin
                    r = 16'($urandom);
                    send_quat(r, $urandom_range(1) ? r : -r, rand_part(), 0);
                end
            endcase
        end
        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("sent %0d quaternions, checked %0d results", sent, results);
        $display("gimbal-clamped results %0d, zero-length results %0d", gimbal_seen,
                 degen_seen);
        if (errors == 0 && pending == 0) begin
            $display("tb_quaternion_to_euler: done, clean");
        end else begin
            $display("tb_quaternion_to_euler: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("tb_quaternion_to_euler: done, errors");
        $finish;
    end

endmodule

FILE: quaternion_to_euler.f
+incdir+src
src/qte_pkg.sv
src/qte_front.sv
src/qte_fifo.sv
src/qte_sqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler.sv
src/qte_checker.sv
dv/quaternion_to_euler_checker.sv
dv/tb_quaternion_to_euler.sv
